// File: src/wsd_pkg.sv
// Package for the wind speed and direction block: word types, widths and
// the CORDIC angle table. Depends on nothing; every other file imports it.
package wsd_pkg;

	localparam int CORDIC_STEPS = 18;
	localparam int ANGLE_STEPS_MAX = 24;
	// Number of micro-rotations actually built.
	localparam int STEPS = (CORDIC_STEPS > ANGLE_STEPS_MAX) ? ANGLE_STEPS_MAX : CORDIC_STEPS;

	localparam int IN_W = 16;
	localparam int OUT_W = 16;
	localparam int FRAC_BITS = 14;
	// CORDIC x and y: 16 bit input, 14 fraction bits, gain headroom and sign.
	localparam int X_W = 34;
	// Magnitude before gain correction stays below 2^31.
	localparam int MAG_W = 31;
	localparam int ANG_W = 32;

	localparam int GAIN_W = 30;
	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int SPD_SH = GAIN_W + FRAC_BITS;
	localparam int SPD_RAW_W = PROD_W + 1 - SPD_SH;

	localparam int DEG_W = 16;
	localparam logic [DEG_W-1:0] DEG_SCALE = 16'd36000;
	localparam int DPROD_W = ANG_W + DEG_W;
	localparam int DIR_RAW_W = DPROD_W + 1 - ANG_W;

	localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32.
	localparam logic [ANG_W-1:0] ATAN_TURN [ANGLE_STEPS_MAX] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [IN_W-1:0] east_wind;
		logic signed [IN_W-1:0] north_wind;
		logic                   east_valid;
		logic                   north_valid;
		logic                   apply_item;
	} obs_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] speed;
		logic [OUT_W-1:0] from_direction;
		logic             result_valid;
	} res_word_t;

endpackage

// File: src/wsd_obs_if.sv
// Observation channel: valid, ready and one observation word.
// Depends on wsd_pkg for the word type.
interface wsd_obs_if import wsd_pkg::*; ();
	logic      valid;
	logic      ready;
	obs_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/wsd_res_if.sv
// Result channel: valid, ready and one speed and direction word.
// Depends on wsd_pkg for the word type.
interface wsd_res_if import wsd_pkg::*; ();
	logic      valid;
	logic      ready;
	res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/wind_speed_direction.sv
// Top level of the wind speed and direction block, a pipelined CORDIC.
// Depends on wsd_pkg and on the channel interfaces wsd_obs_if and wsd_res_if.

// The block takes one observation word per cycle when not stalled (eastward
// and northward wind in 0.01 m/s with their presence flags and an apply
// flag) and returns one result word per observation, in order: the wind
// speed in 0.01 m/s and the direction the wind blows from in 0.01 degree,
// wrapped to [0, 36000). A word with apply clear or a component missing
// gives a result marked invalid with zero speed and direction; a calm wind
// gives a valid result with zero speed and direction. The pipeline is
// STEPS + 3 register stages deep (21 with the default 18 micro-rotations):
// one stage folds the vector into the right half plane, one stage per CORDIC
// micro-rotation, one stage for the gain and degree multipliers and one
// output stage that rounds. A new word can enter on every cycle while the
// result side is ready, so the sustained rate is then one word per cycle.
// When the result side stalls, empty stages still fill, so the input keeps
// taking words until every stage holds one; nothing is dropped or repeated.
module wind_speed_direction import wsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	wsd_obs_if.sink   obs,
	wsd_res_if.source res
);

	// State of the vector as it moves down the rotation chain.
	typedef struct packed {
		logic signed [X_W-1:0] x;
		logic signed [X_W-1:0] y;
		logic [ANG_W-1:0]      ang;
		logic                  ok;
		logic                  calm;
	} rot_t;

	// Stage enables. A stage loads when it is empty or when the stage after
	// it loads in the same cycle, so bubbles are squeezed out during a stall.
	logic en_s1;
	logic ren_s2 [STEPS];
	logic en_s3;
	logic en_s4;

	logic v_s1;
	logic rv_s2 [STEPS];
	logic v_s3;
	logic v_s4;

	always_comb begin
		en_s4 = !v_s4 || res.ready;
		en_s3 = !v_s3 || en_s4;
		ren_s2[STEPS-1] = !rv_s2[STEPS-1] || en_s3;
		for (int i = STEPS - 2; i >= 0; i--) begin
			ren_s2[i] = !rv_s2[i] || ren_s2[i+1];
		end
		en_s1 = !v_s1 || ren_s2[0];
	end

	assign obs.ready = en_s1;

	// Stage 1: scale to the CORDIC format and fold a vector with negative
	// east component by half a turn, so the rotations converge.
	rot_t prep_nx;
	rot_t prep_s1;
	logic signed [X_W-1:0] u_sc;
	logic signed [X_W-1:0] v_sc;

	always_comb begin
		u_sc = $signed({{(X_W-IN_W-FRAC_BITS){obs.data.east_wind[IN_W-1]}},
			obs.data.east_wind, {FRAC_BITS{1'b0}}});
		v_sc = $signed({{(X_W-IN_W-FRAC_BITS){obs.data.north_wind[IN_W-1]}},
			obs.data.north_wind, {FRAC_BITS{1'b0}}});
		prep_nx.ok = obs.data.east_valid && obs.data.north_valid && obs.data.apply_item;
		prep_nx.calm = (obs.data.east_wind == '0) && (obs.data.north_wind == '0);
		if (obs.data.east_wind[IN_W-1]) begin
			prep_nx.x = -u_sc;
			prep_nx.y = -v_sc;
			prep_nx.ang = HALF_TURN;
		end else begin
			prep_nx.x = u_sc;
			prep_nx.y = v_sc;
			prep_nx.ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= obs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prep_s1 <= prep_nx;
		end
	end

	// Stage 2: one register stage per micro-rotation. Each stage drives y
	// toward zero and accumulates the turned angle.
	rot_t rot_s2 [STEPS];

	for (genvar g = 0; g < STEPS; g++) begin : g_rot
		rot_t src;
		rot_t nxt;
		logic src_v;
		logic signed [X_W-1:0] xs;
		logic signed [X_W-1:0] ys;

		if (g == 0) begin : g_first
			assign src = prep_s1;
			assign src_v = v_s1;
		end else begin : g_next
			assign src = rot_s2[g-1];
			assign src_v = rv_s2[g-1];
		end

		// Arithmetic shifts round toward minus infinity.
		assign xs = $signed(src.x) >>> g;
		assign ys = $signed(src.y) >>> g;

		always_comb begin
			nxt = src;
			if (!src.y[X_W-1]) begin
				nxt.x = src.x + ys;
				nxt.y = src.y - xs;
				nxt.ang = src.ang + ATAN_TURN[g];
			end else begin
				nxt.x = src.x - ys;
				nxt.y = src.y + xs;
				nxt.ang = src.ang - ATAN_TURN[g];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s2[g] <= 1'b0;
			end else if (ren_s2[g]) begin
				rv_s2[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (ren_s2[g]) begin
				rot_s2[g] <= nxt;
			end
		end
	end

	// Stage 3: gain correction of the magnitude and conversion of the
	// from-angle to hundredths of a degree, one multiplier each.
	rot_t last;
	logic [MAG_W-1:0] mag;
	logic [ANG_W-1:0] from_ang;
	logic [PROD_W-1:0] spd_prod_s3;
	logic [DPROD_W-1:0] dir_prod_s3;
	logic ok_s3;
	logic calm_s3;

	assign last = rot_s2[STEPS-1];
	assign mag = last.x[X_W-1] ? '0 : last.x[MAG_W-1:0];
	assign from_ang = THREE_QUARTER_TURN - last.ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= rv_s2[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			spd_prod_s3 <= PROD_W'(mag) * PROD_W'(GAIN_Q30);
			dir_prod_s3 <= DPROD_W'(from_ang) * DPROD_W'(DEG_SCALE);
			ok_s3 <= last.ok;
			calm_s3 <= last.calm;
		end
	end

	// Stage 4: round half up, saturate the speed, wrap a full circle to
	// zero, and apply the missing and calm cases. This is the output register.
	logic [PROD_W:0] spd_sum;
	logic [SPD_RAW_W-1:0] spd_raw;
	logic [OUT_W-1:0] spd_val;
	logic [DPROD_W:0] dir_sum;
	logic [DIR_RAW_W-1:0] dir_raw;
	logic [OUT_W-1:0] dir_val;
	res_word_t res_nx;
	res_word_t res_s4;

	always_comb begin
		spd_sum = {1'b0, spd_prod_s3} + ((PROD_W+1)'(1) << (SPD_SH - 1));
		spd_raw = spd_sum[PROD_W:SPD_SH];
		spd_val = (spd_raw > SPD_RAW_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : spd_raw[OUT_W-1:0];
		dir_sum = {1'b0, dir_prod_s3} + ((DPROD_W+1)'(1) << (ANG_W - 1));
		dir_raw = dir_sum[DPROD_W:ANG_W];
		dir_val = (dir_raw >= DIR_RAW_W'(DEG_SCALE)) ? '0 : dir_raw[OUT_W-1:0];
		if (!ok_s3) begin
			res_nx = '0;
		end else if (calm_s3) begin
			res_nx.speed = '0;
			res_nx.from_direction = '0;
			res_nx.result_valid = 1'b1;
		end else begin
			res_nx.speed = spd_val;
			res_nx.from_direction = dir_val;
			res_nx.result_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_s4 <= res_nx;
		end
	end

	assign res.valid = v_s4;
	assign res.data = res_s4;

`ifndef SYNTH
	// An empty output register means the whole pipeline can move.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> obs.ready)
		else $error("input stalled while the output stage is empty");

	// A result being taken frees a slot, so the input must be open.
	a_ready_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && res.ready) |-> obs.ready)
		else $error("input stalled while a result is taken");

	// A word marked invalid carries zero speed and direction.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.data.result_valid) |->
		(res.data.speed == '0 && res.data.from_direction == '0))
		else $error("invalid result with nonzero payload");

	// The direction never reaches a full circle.
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.data.from_direction < DEG_SCALE))
		else $error("direction out of range");

	// A word taken at the input is in the first stage on the next cycle.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(obs.valid && obs.ready) |=> v_s1)
		else $error("accepted word lost at the first stage");
`endif

endmodule
